// ----- hdl/vfcam_pkg.sv -----
// Package for the voxel face culling and ambient occlusion mesher.
// Holds field widths, face and texture-corner codes and the sequencer program.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package vfcam_pkg;

  localparam int CHUNK_SIDE = 16;
  localparam int CHUNK_TALL = 256;

  localparam int POS_XZ_W   = 4;
  localparam int POS_Y_W    = 8;
  localparam int ID_W       = 16;
  localparam int MASK_W     = 27;
  localparam int BIT_IDX_W  = 5;
  localparam int NUM_FACES  = 6;
  localparam int VERT_IDX_W = 3;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef logic [1:0] uv_t;
  localparam uv_t UV_TOP_LEFT     = 2'd0;
  localparam uv_t UV_BOTTOM_LEFT  = 2'd1;
  localparam uv_t UV_BOTTOM_RIGHT = 2'd2;
  localparam uv_t UV_TOP_RIGHT    = 2'd3;

  // Solidity bit of the neighbor across each face, indexed by face code.
  localparam logic [BIT_IDX_W-1:0] FACE_BIT [NUM_FACES] = '{
    5'd14, 5'd12, 5'd22, 5'd4, 5'd16, 5'd10
  };

  // One control word per vertex step. A set corner bit means offset +1.
  typedef struct packed {
    face_t                 face;
    logic                  cx;
    logic                  cy;
    logic                  cz;
    uv_t                   uv;
    logic [BIT_IDX_W-1:0]  occ_a;
    logic [BIT_IDX_W-1:0]  occ_b;
    logic [BIT_IDX_W-1:0]  occ_c;
    logic                  face_end;
  } ctrl_t;

  typedef struct packed {
    logic  found;
    face_t face;
  } face_sel_t;

  function automatic ctrl_t mk(face_t f, logic sx, logic sy, logic sz, uv_t uv, logic fe);
    int    gx;
    int    gy;
    int    gz;
    ctrl_t c;
    gx = sx ? 2 : 0;
    gy = sy ? 2 : 0;
    gz = sz ? 2 : 0;
    c.face     = f;
    c.cx       = sx;
    c.cy       = sy;
    c.cz       = sz;
    c.uv       = uv;
    c.face_end = fe;
    c.occ_a    = BIT_IDX_W'(gy * 9 + gz * 3 + gx);
    case (f)
      FACE_POS_X, FACE_NEG_X: begin
        c.occ_b = BIT_IDX_W'(9 + gz * 3 + gx);
        c.occ_c = BIT_IDX_W'(gy * 9 + 3 + gx);
      end
      FACE_POS_Y, FACE_NEG_Y: begin
        c.occ_b = BIT_IDX_W'(gy * 9 + 3 + gx);
        c.occ_c = BIT_IDX_W'(gy * 9 + gz * 3 + 1);
      end
      default: begin
        c.occ_b = BIT_IDX_W'(9 + gz * 3 + gx);
        c.occ_c = BIT_IDX_W'(gy * 9 + gz * 3 + 1);
      end
    endcase
    return c;
  endfunction

  // Sequencer program, indexed by face and vertex step.
  localparam ctrl_t PROG [NUM_FACES][6] = '{
    '{mk(FACE_POS_X, 1, 1, 1, UV_TOP_LEFT,     0), mk(FACE_POS_X, 1, 0, 1, UV_BOTTOM_LEFT,  0),
      mk(FACE_POS_X, 1, 0, 0, UV_BOTTOM_RIGHT, 0), mk(FACE_POS_X, 1, 1, 1, UV_TOP_LEFT,     0),
      mk(FACE_POS_X, 1, 0, 0, UV_BOTTOM_RIGHT, 0), mk(FACE_POS_X, 1, 1, 0, UV_TOP_RIGHT,    1)},
    '{mk(FACE_NEG_X, 0, 1, 1, UV_TOP_RIGHT,    0), mk(FACE_NEG_X, 0, 0, 0, UV_BOTTOM_LEFT,  0),
      mk(FACE_NEG_X, 0, 0, 1, UV_BOTTOM_RIGHT, 0), mk(FACE_NEG_X, 0, 1, 1, UV_TOP_RIGHT,    0),
      mk(FACE_NEG_X, 0, 1, 0, UV_TOP_LEFT,     0), mk(FACE_NEG_X, 0, 0, 0, UV_BOTTOM_LEFT,  1)},
    '{mk(FACE_POS_Y, 0, 1, 0, UV_TOP_LEFT,     0), mk(FACE_POS_Y, 0, 1, 1, UV_BOTTOM_LEFT,  0),
      mk(FACE_POS_Y, 1, 1, 1, UV_BOTTOM_RIGHT, 0), mk(FACE_POS_Y, 0, 1, 0, UV_TOP_LEFT,     0),
      mk(FACE_POS_Y, 1, 1, 1, UV_BOTTOM_RIGHT, 0), mk(FACE_POS_Y, 1, 1, 0, UV_TOP_RIGHT,    1)},
    '{mk(FACE_NEG_Y, 0, 0, 0, UV_TOP_RIGHT,    0), mk(FACE_NEG_Y, 1, 0, 1, UV_BOTTOM_LEFT,  0),
      mk(FACE_NEG_Y, 0, 0, 1, UV_BOTTOM_RIGHT, 0), mk(FACE_NEG_Y, 0, 0, 0, UV_TOP_RIGHT,    0),
      mk(FACE_NEG_Y, 1, 0, 0, UV_TOP_LEFT,     0), mk(FACE_NEG_Y, 1, 0, 1, UV_BOTTOM_LEFT,  1)},
    '{mk(FACE_POS_Z, 0, 1, 1, UV_TOP_LEFT,     0), mk(FACE_POS_Z, 0, 0, 1, UV_BOTTOM_LEFT,  0),
      mk(FACE_POS_Z, 1, 0, 1, UV_BOTTOM_RIGHT, 0), mk(FACE_POS_Z, 0, 1, 1, UV_TOP_LEFT,     0),
      mk(FACE_POS_Z, 1, 0, 1, UV_BOTTOM_RIGHT, 0), mk(FACE_POS_Z, 1, 1, 1, UV_TOP_RIGHT,    1)},
    '{mk(FACE_NEG_Z, 0, 1, 0, UV_TOP_RIGHT,    0), mk(FACE_NEG_Z, 1, 0, 0, UV_BOTTOM_LEFT,  0),
      mk(FACE_NEG_Z, 0, 0, 0, UV_BOTTOM_RIGHT, 0), mk(FACE_NEG_Z, 0, 1, 0, UV_TOP_RIGHT,    0),
      mk(FACE_NEG_Z, 1, 1, 0, UV_TOP_LEFT,     0), mk(FACE_NEG_Z, 1, 0, 0, UV_BOTTOM_LEFT,  1)}
  };

  // Lowest emitted face at or above the given face code.
  function automatic face_sel_t first_face(logic [NUM_FACES-1:0] emit, logic [2:0] from);
    face_sel_t s;
    s.found = 1'b0;
    s.face  = FACE_POS_X;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (emit[f] && (3'(f) >= from)) begin
        s.found = 1'b1;
        s.face  = face_t'(3'(f));
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/voxel_face_cull_ao_mesher.sv -----
// Top level of the voxel face culling and ambient occlusion mesher.
// Sequencer, datapath and output register; depends on vfcam_pkg.
`default_nettype none

// Takes one voxel per request and emits one vertex per cycle while the output
// is not stalled, six per visible face, faces in the order +x, -x, +y, -y, +z,
// -z, with tlast on the final vertex. A voxel occupies the block from its
// request until its final vertex moves into the output register. An empty or
// fully enclosed voxel gives nothing and leaves in_tready high. The sequencer
// steps through one control word of its program per cycle while not stalled
// and jumps over hidden faces at no cost; it holds while a vertex waits in
// the output register. The next voxel is accepted in the cycle after the
// final vertex has moved into the output register, while that vertex still
// waits to be taken.
module voxel_face_cull_ao_mesher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pos_x[3:0], pos_y[11:4], pos_z[15:12], block_id[31:16], solid_mask[58:32]
  input  logic [vfcam_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // vert_x[4:0], vert_y[13:5], vert_z[18:14], face[21:19], uv_corner[23:22],
  // occlusion[25:24], out_block_id[41:26]
  output logic [vfcam_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tlast
);
  import vfcam_pkg::*;

  logic [POS_XZ_W-1:0]    in_px;
  logic [POS_Y_W-1:0]     in_py;
  logic [POS_XZ_W-1:0]    in_pz;
  logic [ID_W-1:0]        in_id;
  logic [MASK_W-1:0]      in_mask;
  logic [POS_XZ_W-1:0]    px_c;
  logic [POS_Y_W-1:0]     py_c;
  logic [POS_XZ_W-1:0]    pz_c;
  logic [NUM_FACES-1:0]   emit_c;
  face_sel_t              start_sel;
  face_sel_t              next_sel;
  ctrl_t                  ctrl;
  logic                   step;
  logic                   accept;

  logic                   busy_r, busy_nxt;
  face_t                  face_r, face_nxt;
  logic [VERT_IDX_W-1:0]  vert_r, vert_nxt;
  logic [NUM_FACES-1:0]   emit_r;
  logic [POS_XZ_W-1:0]    px_r;
  logic [POS_Y_W-1:0]     py_r;
  logic [POS_XZ_W-1:0]    pz_r;
  logic [ID_W-1:0]        id_r;
  logic [MASK_W-1:0]      mask_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [4:0]             vx;
  logic [8:0]             vy;
  logic [4:0]             vz;
  logic [1:0]             occ;

  assign in_px   = in_tdata[3:0];
  assign in_py   = in_tdata[11:4];
  assign in_pz   = in_tdata[15:12];
  assign in_id   = in_tdata[31:16];
  assign in_mask = in_tdata[58:32];

  assign px_c = (32'(in_px) >= CHUNK_SIDE) ? POS_XZ_W'(CHUNK_SIDE - 1) : in_px;
  assign py_c = (32'(in_py) >= CHUNK_TALL) ? POS_Y_W'(CHUNK_TALL - 1) : in_py;
  assign pz_c = (32'(in_pz) >= CHUNK_SIDE) ? POS_XZ_W'(CHUNK_SIDE - 1) : in_pz;

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      emit_c[f] = ~in_mask[FACE_BIT[f]];
    end
    if (py_c == '0) begin
      emit_c[FACE_NEG_Y] = 1'b0;
    end
  end

  assign start_sel = first_face(emit_c, 3'd0);
  assign next_sel  = first_face(emit_r, 3'(face_r) + 3'd1);
  assign ctrl      = PROG[face_r][vert_r];

  assign in_tready = ~busy_r;
  assign accept    = in_tvalid & ~busy_r;
  assign step      = busy_r & (~out_valid_r | out_tready);

  assign vx  = {1'b0, px_r} + {4'd0, ctrl.cx};
  assign vy  = {1'b0, py_r} + {8'd0, ctrl.cy};
  assign vz  = {1'b0, pz_r} + {4'd0, ctrl.cz};
  assign occ = {1'b0, mask_r[ctrl.occ_a]} + {1'b0, mask_r[ctrl.occ_b]}
             + {1'b0, mask_r[ctrl.occ_c]};

  always_comb begin
    busy_nxt      = busy_r;
    face_nxt      = face_r;
    vert_nxt      = vert_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (step) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'd0, id_r, occ, ctrl.uv, 3'(ctrl.face), vz, vy, vx};
      out_last_nxt  = ctrl.face_end & ~next_sel.found;
      if (ctrl.face_end) begin
        vert_nxt = '0;
        if (next_sel.found) begin
          face_nxt = next_sel.face;
        end else begin
          busy_nxt = 1'b0;
        end
      end else begin
        vert_nxt = vert_r + VERT_IDX_W'(1);
      end
    end
    if (accept) begin
      face_nxt = start_sel.face;
      vert_nxt = '0;
      busy_nxt = (in_id != '0) & start_sel.found;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (accept) begin
      emit_r <= emit_c;
      px_r   <= px_c;
      py_r   <= py_c;
      pz_r   <= pz_c;
      id_r   <= in_id;
      mask_r <= in_mask;
    end
    if (!rst_n) begin
      busy_r      <= 1'b0;
      face_r      <= FACE_POS_X;
      vert_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      face_r      <= face_nxt;
      vert_r      <= vert_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/vfcam_chk.sv -----
// Port checker for the voxel face culling and ambient occlusion mesher.
// Watches the top-level ports only and is bound to the top level below.
`default_nettype none

module vfcam_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [vfcam_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [vfcam_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                               out_tlast
);
  import vfcam_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled vertex changed");

  a_face_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[21:19] <= 3'(FACE_NEG_Z))
    else $error("face code out of range");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[41:26] != '0)
    else $error("vertex from an empty voxel");

  a_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[31:16] == '0 |=> in_tready)
    else $error("empty voxel occupied the block");

endmodule

bind voxel_face_cull_ao_mesher vfcam_chk u_vfcam_chk (.*);

`default_nettype wire
